// ===== sv/pfde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types, constants and helpers of the page frame store draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int HEIGHT      = PAGES * 8;
    localparam int STORE_DEPTH = PAGES * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PG_W        = 5;   // holds a page count up to 31
    localparam int COL_W       = 8;
    localparam int ROW_W       = 9;

    localparam logic [2:0] REQ_POINT  = 3'd0;
    localparam logic [2:0] REQ_RECT   = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_SCROLL = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [2:0] {
        MODE_RECT  = 3'd0,
        MODE_CLEAR = 3'd1,
        MODE_READ  = 3'd2,
        MODE_UP    = 3'd3,
        MODE_DOWN  = 3'd4,
        MODE_LEFT  = 3'd5,
        MODE_RIGHT = 3'd6
    } mode_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] span_w;
        logic [7:0] span_h;
        logic       pixel_on;
        logic [1:0] scroll_dir;
        logic [3:0] scroll_amount;
        logic [7:0] scroll_repeat;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ignored;
    } rsp_t;

    // decoded request: region bounds and walk controls
    typedef struct packed {
        logic             active;
        mode_t            mode;
        logic             ignored;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic [PG_W-1:0]  p0;
        logic [PG_W-1:0]  p1;
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic             on;
        logic [3:0]       amt;
        logic [7:0]       rep;
    } job_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [PG_W-1:0] p,
                                                     input logic [COL_W-1:0] c);
        store_addr = ADDR_W'(ADDR_W'(p) * ADDR_W'(COLUMNS) + ADDR_W'(c));
    endfunction

endpackage
`default_nettype wire

// ===== sv/pfde_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/pfde_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_decode
// Turns a request word into clipped region bounds and a walk mode.
// ----------------------------------------------------------------------------
module pfde_decode
    import pfde_pkg::*;
(
    input  wire req_t req,
    output job_t      job
);

    logic [8:0]       col_sum;
    logic [COL_W-1:0] c1_clip;
    logic             off_screen;
    logic [8:0]       row_sum;
    logic [ROW_W-1:0] r1_pix;
    logic [ROW_W-1:0] r1_m1;
    logic [8:0]       pg_sum;
    logic [PG_W-1:0]  p1_clip;
    logic             clip_ok;
    logic [3:0]       amt;
    logic             is_point;

    always_comb
    begin
        is_point   = (req.req_type == REQ_POINT);
        col_sum    = {1'b0, req.col} + {1'b0, req.span_w};
        c1_clip    = (col_sum > 9'(COLUMNS)) ? COL_W'(COLUMNS) : col_sum[7:0];
        off_screen = ({1'b0, req.col} >= 9'(COLUMNS)) || ({1'b0, req.row} >= 9'(HEIGHT));
        row_sum    = {1'b0, req.row} + (is_point ? 9'd1 : {1'b0, req.span_h});
        r1_pix     = (row_sum > 9'(HEIGHT)) ? ROW_W'(HEIGHT) : row_sum;
        r1_m1      = r1_pix - ROW_W'(1);
        pg_sum     = {1'b0, req.row} + {1'b0, req.span_h};
        p1_clip    = (pg_sum > 9'(PAGES)) ? PG_W'(PAGES) : pg_sum[PG_W-1:0];
        clip_ok    = ({1'b0, req.col} < 9'(COLUMNS)) && ({1'b0, req.row} < 9'(PAGES))
                     && (req.span_w != 8'd0) && (req.span_h != 8'd0);
        amt        = req.scroll_amount;
        if (req.scroll_dir == DIR_UP || req.scroll_dir == DIR_DOWN)
        begin
            if (amt > 4'd8)
            begin
                amt = 4'd8;
            end
        end

        job         = '0;
        job.mode    = MODE_CLEAR;
        job.on      = req.pixel_on;
        job.amt     = amt;
        job.rep     = 8'd1;
        job.c0      = req.col;
        job.c1      = c1_clip;
        job.p0      = req.row[PG_W-1:0];
        job.p1      = p1_clip;
        job.r0      = {1'b0, req.row};
        job.r1      = r1_pix;

        case (req.req_type)
            REQ_POINT, REQ_RECT:
            begin
                job.mode    = MODE_RECT;
                job.ignored = off_screen;
                job.p0      = PG_W'(req.row[7:3]);
                job.p1      = PG_W'(r1_m1[7:3]) + PG_W'(1);
                if (is_point)
                begin
                    job.c1     = req.col + 8'd1;
                    job.active = !off_screen;
                end
                else
                begin
                    job.active = !off_screen && (req.span_w != 8'd0)
                                 && (req.span_h != 8'd0);
                end
            end
            REQ_CLEAR:
            begin
                job.mode   = MODE_CLEAR;
                job.active = clip_ok;
            end
            REQ_SCROLL:
            begin
                case (req.scroll_dir)
                    DIR_UP:   job.mode = MODE_UP;
                    DIR_DOWN: job.mode = MODE_DOWN;
                    DIR_LEFT: job.mode = MODE_LEFT;
                    default:  job.mode = MODE_RIGHT;
                endcase
                job.rep    = req.scroll_repeat;
                job.active = clip_ok && (amt != 4'd0) && (req.scroll_repeat != 8'd0);
            end
            REQ_READ:
            begin
                job.mode   = MODE_READ;
                job.c1     = req.col + 8'd1;
                job.p1     = req.row[PG_W-1:0] + PG_W'(1);
                job.active = ({1'b0, req.col} < 9'(COLUMNS)) && ({1'b0, req.row} < 9'(PAGES));
            end
            default:
            begin
                job.active = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/page_framebuffer_draw_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page frame store with point, fill, clear, scroll and read.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) takes one request word; the
//   engine answers every request with one rsp word on rsp_valid / rsp_stall.
//   The store is PAGES x COLUMNS bytes in one RAM with a registered read.
//   Each touched byte takes a read step, then a write step; clear skips
//   the read and a read request the write. Point and read touch one
//   byte; fill, clear and scroll touch the clipped region, scroll once
//   per repeat; a rejected request touches none. Scroll up/down adds one
//   priming read per line, a line being one column; left/right adds none.
//   A full frame pass is bounded by the single RAM port pair.
//   req_stall is high while a request is being worked on.
//   After reset the engine zeroes the store, one byte a cycle, while
//   req_stall stays high.
//   A stalled response holds; the next request can be taken while it waits.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine
    import pfde_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_PRIME = 7'b0001000,
        S_RD    = 7'b0010000,
        S_WR    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    job_t              job_reg, job_next, dec_job;
    logic [PG_W-1:0]   pp_reg, pp_next;
    logic [COL_W-1:0]  cc_reg, cc_next;
    logic [7:0]        rep_reg, rep_next;
    logic [7:0]        cur_reg, cur_next;
    logic              prime_reg, prime_next;
    logic              has_reg, has_next;
    logic [7:0]        rdbyte_reg, rdbyte_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, dst;
    logic [7:0]        ram_wdata, ram_rdata;

    logic              page_inner, inner_end, outer_end;
    logic [PG_W-1:0]   pp_start;
    logic [COL_W-1:0]  cc_start;
    logic [8:0]        fwd_src, back_lim;
    logic [7:0]        mask, nb;
    logic [ROW_W-1:0]  ypix;

    pfde_decode u_decode (
        .req (req),
        .job (dec_job)
    );

    pfde_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        page_inner = (job_reg.mode == MODE_UP) || (job_reg.mode == MODE_DOWN);
        pp_start   = (job_reg.mode == MODE_DOWN) ? job_reg.p1 - PG_W'(1) : job_reg.p0;
        cc_start   = (job_reg.mode == MODE_RIGHT) ? job_reg.c1 - 8'd1 : job_reg.c0;
        dst        = store_addr(pp_reg, cc_reg);
        fwd_src    = {1'b0, cc_reg} + 9'(job_reg.amt);
        back_lim   = {1'b0, job_reg.c0} + 9'(job_reg.amt);

        case (job_reg.mode)
            MODE_UP:    inner_end = (pp_reg == job_reg.p1 - PG_W'(1));
            MODE_DOWN:  inner_end = (pp_reg == job_reg.p0);
            MODE_RIGHT: inner_end = (cc_reg == job_reg.c0);
            default:    inner_end = (cc_reg == job_reg.c1 - 8'd1);
        endcase
        outer_end = page_inner ? (cc_reg == job_reg.c1 - 8'd1)
                               : (pp_reg == job_reg.p1 - PG_W'(1));

        // pixel rows of this page that fall inside the fill
        for (int b = 0; b < 8; b++)
        begin
            ypix    = ROW_W'({pp_reg, 3'b000}) + ROW_W'(b);
            mask[b] = (ypix >= job_reg.r0) && (ypix < job_reg.r1);
        end
        nb = has_reg ? ram_rdata : 8'd0;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        pp_next        = pp_reg;
        cc_next        = cc_reg;
        rep_next       = rep_reg;
        cur_next       = cur_reg;
        prime_next     = prime_reg;
        has_next       = has_reg;
        rdbyte_next    = rdbyte_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = dst;
        ram_wdata      = 8'd0;
        ram_re         = 1'b0;
        ram_raddr      = dst;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    job_next   = dec_job;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                pp_next  = pp_start;
                cc_next  = cc_start;
                rep_next = job_reg.rep;
                if (!job_reg.active)
                begin
                    state_next = S_DONE;
                end
                else if (page_inner)
                begin
                    state_next = S_PRIME;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PRIME:
            begin
                ram_re     = 1'b1;
                prime_next = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (prime_reg)
                begin
                    cur_next = ram_rdata;
                end
                prime_next = 1'b0;
                has_next   = 1'b0;
                case (job_reg.mode)
                    MODE_RECT, MODE_READ:
                    begin
                        ram_re = 1'b1;
                    end
                    MODE_UP:
                    begin
                        has_next  = (pp_reg + PG_W'(1) < job_reg.p1);
                        ram_re    = has_next;
                        ram_raddr = store_addr(pp_reg + PG_W'(1), cc_reg);
                    end
                    MODE_DOWN:
                    begin
                        has_next  = (pp_reg > job_reg.p0);
                        ram_re    = has_next;
                        ram_raddr = store_addr(pp_reg - PG_W'(1), cc_reg);
                    end
                    MODE_LEFT:
                    begin
                        has_next  = (fwd_src < {1'b0, job_reg.c1});
                        ram_re    = has_next;
                        ram_raddr = store_addr(pp_reg, fwd_src[7:0]);
                    end
                    MODE_RIGHT:
                    begin
                        has_next  = ({1'b0, cc_reg} >= back_lim);
                        ram_re    = has_next;
                        ram_raddr = store_addr(pp_reg, cc_reg - 8'(job_reg.amt));
                    end
                    default:
                    begin
                        ram_re = 1'b0;
                    end
                endcase
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we = 1'b1;
                case (job_reg.mode)
                    MODE_RECT:
                    begin
                        ram_wdata = (ram_rdata & ~mask) | (job_reg.on ? mask : 8'd0);
                    end
                    MODE_READ:
                    begin
                        ram_we      = 1'b0;
                        rdbyte_next = ram_rdata;
                    end
                    MODE_UP:
                    begin
                        ram_wdata = 8'({nb, cur_reg} >> job_reg.amt);
                        cur_next  = nb;
                    end
                    MODE_DOWN:
                    begin
                        ram_wdata = 8'(({cur_reg, nb} << job_reg.amt) >> 8);
                        cur_next  = nb;
                    end
                    MODE_LEFT, MODE_RIGHT:
                    begin
                        ram_wdata = nb;
                    end
                    default:
                    begin
                        ram_wdata = 8'd0;
                    end
                endcase

                if (!inner_end)
                begin
                    if (job_reg.mode == MODE_UP)
                        pp_next = pp_reg + PG_W'(1);
                    else if (job_reg.mode == MODE_DOWN)
                        pp_next = pp_reg - PG_W'(1);
                    else if (job_reg.mode == MODE_RIGHT)
                        cc_next = cc_reg - 8'd1;
                    else
                        cc_next = cc_reg + 8'd1;
                    state_next = S_RD;
                end
                else if (!outer_end)
                begin
                    if (page_inner)
                    begin
                        pp_next = pp_start;
                        cc_next = cc_reg + 8'd1;
                    end
                    else
                    begin
                        cc_next = cc_start;
                        pp_next = pp_reg + PG_W'(1);
                    end
                    state_next = page_inner ? S_PRIME : S_RD;
                end
                else if (rep_reg != 8'd1)
                begin
                    rep_next   = rep_reg - 8'd1;
                    pp_next    = pp_start;
                    cc_next    = cc_start;
                    state_next = page_inner ? S_PRIME : S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.read_data = (job_reg.mode == MODE_READ && job_reg.active)
                                         ? rdbyte_reg : 8'd0;
                    out_next.ignored   = job_reg.ignored;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        pp_reg     <= pp_next;
        cc_reg     <= cc_next;
        rep_reg    <= rep_next;
        cur_reg    <= cur_next;
        prime_reg  <= prime_next;
        has_reg    <= has_next;
        rdbyte_reg <= rdbyte_next;
        out_reg    <= out_next;
    end

endmodule
`default_nettype wire

// ===== sv/pfde_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_chk
// Port-level checks on the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module pfde_chk
    import pfde_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response word changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("engine took a second request without working the first");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ignored |-> rsp.read_data == 8'd0)
        else $error("rejected request returned data");

endmodule

bind page_framebuffer_draw_engine pfde_chk u_chk (.*);
`default_nettype wire
